FILE: rtl/obm_pkg.sv
// ----------------------------------------------------------------------------
// obm_pkg
// shared widths, field layouts, state and command types of the bar merger
// ----------------------------------------------------------------------------
package obm_pkg;

  localparam int PRICE_BITS  = 24;
  localparam int VOLUME_BITS = 24;

  localparam int TIME_BITS   = 63;
  localparam int TRADES_BITS = 16;
  localparam int VSUM_BITS   = 40;
  localparam int TSUM_BITS   = 32;
  localparam int WSUM_BITS   = 64;
  localparam int PROD_BITS   = PRICE_BITS + VOLUME_BITS;

  localparam int DIV_CNT_BITS = $clog2(WSUM_BITS + 1);

  // input tdata layout, lowest field first
  localparam int IN_OPEN_LSB   = TIME_BITS;
  localparam int IN_HIGH_LSB   = IN_OPEN_LSB + PRICE_BITS;
  localparam int IN_LOW_LSB    = IN_HIGH_LSB + PRICE_BITS;
  localparam int IN_CLOSE_LSB  = IN_LOW_LSB + PRICE_BITS;
  localparam int IN_VOL_LSB    = IN_CLOSE_LSB + PRICE_BITS;
  localparam int IN_TRADES_LSB = IN_VOL_LSB + VOLUME_BITS;
  localparam int IN_VWAP_LSB   = IN_TRADES_LSB + TRADES_BITS;
  localparam int IN_FIELD_BITS = IN_VWAP_LSB + PRICE_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

  localparam int OUT_FIELD_BITS = TIME_BITS + 5 * PRICE_BITS + VSUM_BITS + TSUM_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_USER_BITS  = 2;

  typedef struct packed {
    logic [PRICE_BITS-1:0]  bar_vwap;
    logic [TRADES_BITS-1:0] bar_trades;
    logic [VOLUME_BITS-1:0] bar_volume;
    logic [PRICE_BITS-1:0]  close_price;
    logic [PRICE_BITS-1:0]  low_price;
    logic [PRICE_BITS-1:0]  high_price;
    logic [PRICE_BITS-1:0]  open_price;
    logic [TIME_BITS-1:0]   bar_time;
  } bar_t;

  typedef struct packed {
    logic                  overflowed;
    logic                  zero_volume;
    logic [PRICE_BITS-1:0] merged_vwap;
    logic [TSUM_BITS-1:0]  merged_trades;
    logic [VSUM_BITS-1:0]  merged_volume;
    logic [PRICE_BITS-1:0] merged_close;
    logic [PRICE_BITS-1:0] merged_low;
    logic [PRICE_BITS-1:0] merged_high;
    logic [PRICE_BITS-1:0] merged_open;
    logic [TIME_BITS-1:0]  merged_time;
  } merged_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_START,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic accept;       // bar transaction taken this cycle
    logic close_group;  // accepted bar ends its group
    logic div_start;    // launch the vwap division
    logic load_out;     // capture merged bar into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

FILE: rtl/obm_div.sv
// ----------------------------------------------------------------------------
// obm_div
// restoring divider, one quotient bit per cycle, weighted sum by volume sum
// ----------------------------------------------------------------------------
module obm_div
  import obm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WSUM_BITS-1:0] dividend,
  input  logic [VSUM_BITS-1:0] divisor,
  output logic                 done,
  output logic [WSUM_BITS-1:0] quotient
);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [VSUM_BITS-1:0]    rem_r, rem_nxt;
  logic [WSUM_BITS-1:0]    quo_r, quo_nxt;
  logic [VSUM_BITS-1:0]    dvs_r, dvs_nxt;
  logic [VSUM_BITS:0]      rem_shift;
  logic [VSUM_BITS:0]      diff;
  logic                    fits;

  always_comb begin
    rem_shift = {rem_r, quo_r[WSUM_BITS-1]};
    diff      = rem_shift - {1'b0, dvs_r};
    fits      = (rem_shift >= {1'b0, dvs_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_BITS'(WSUM_BITS);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[VSUM_BITS-1:0] : rem_shift[VSUM_BITS-1:0];
      quo_nxt = {quo_r[WSUM_BITS-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_BITS'(1);
      if (cnt_r == DIV_CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider busy with spent count");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("division started while busy");

  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("done without a finished division");

endmodule

FILE: rtl/obm_datapath.sv
// ----------------------------------------------------------------------------
// obm_datapath
// group accumulators, product register, divider and merged output register
// ----------------------------------------------------------------------------
module obm_datapath
  import obm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  bar_t    in_bar,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output merged_t out_bar
);

  logic                   in_group_r, in_group_nxt;
  logic                   pend_r, pend_nxt;
  logic [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic [TIME_BITS-1:0]   first_time_r, first_time_nxt;
  logic [PRICE_BITS-1:0]  first_open_r, first_open_nxt;
  logic [PRICE_BITS-1:0]  first_vwap_r, first_vwap_nxt;
  logic [PRICE_BITS-1:0]  run_high_r, run_high_nxt;
  logic [PRICE_BITS-1:0]  run_low_r, run_low_nxt;
  logic [PRICE_BITS-1:0]  last_close_r, last_close_nxt;
  logic [VSUM_BITS-1:0]   vsum_r, vsum_nxt;
  logic [TSUM_BITS-1:0]   tsum_r, tsum_nxt;
  logic [WSUM_BITS-1:0]   wsum_r, wsum_nxt;
  logic                   sat_r, sat_nxt;
  merged_t                out_r, out_nxt;

  logic                   start_grp;
  logic [VSUM_BITS:0]     vsum_add;
  logic [TSUM_BITS:0]     tsum_add;
  logic [WSUM_BITS:0]     wsum_add;
  logic                   vsum_sat, tsum_sat, wsum_sat;
  logic                   div_done;
  logic [WSUM_BITS-1:0]   quotient;
  logic [PRICE_BITS-1:0]  vwap_clamped;

  obm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (wsum_r),
    .divisor  (vsum_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    start_grp = !in_group_r;

    // a new group starts its sums from zero
    vsum_add = {1'b0, (start_grp ? '0 : vsum_r)}
             + (VSUM_BITS+1)'(in_bar.bar_volume);
    tsum_add = {1'b0, (start_grp ? '0 : tsum_r)}
             + (TSUM_BITS+1)'(in_bar.bar_trades);
    wsum_add = {1'b0, wsum_r} + (WSUM_BITS+1)'(prod_r);
    vsum_sat = vsum_add[VSUM_BITS];
    tsum_sat = tsum_add[TSUM_BITS];
    wsum_sat = wsum_add[WSUM_BITS];

    in_group_nxt   = in_group_r;
    pend_nxt       = cmd.accept;
    prod_nxt       = prod_r;
    first_time_nxt = first_time_r;
    first_open_nxt = first_open_r;
    first_vwap_nxt = first_vwap_r;
    run_high_nxt   = run_high_r;
    run_low_nxt    = run_low_r;
    last_close_nxt = last_close_r;
    vsum_nxt       = vsum_r;
    tsum_nxt       = tsum_r;
    wsum_nxt       = wsum_r;
    sat_nxt        = sat_r;

    // product of the previous bar folds in the cycle after that bar was accepted
    if (pend_r) begin
      wsum_nxt = wsum_sat ? '1 : wsum_add[WSUM_BITS-1:0];
      sat_nxt  = sat_r | wsum_sat;
    end

    if (cmd.accept) begin
      prod_nxt       = PROD_BITS'(in_bar.bar_vwap) * PROD_BITS'(in_bar.bar_volume);
      last_close_nxt = in_bar.close_price;
      vsum_nxt       = vsum_sat ? '1 : vsum_add[VSUM_BITS-1:0];
      tsum_nxt       = tsum_sat ? '1 : tsum_add[TSUM_BITS-1:0];
      in_group_nxt   = !cmd.close_group;
      if (start_grp) begin
        first_time_nxt = in_bar.bar_time;
        first_open_nxt = in_bar.open_price;
        first_vwap_nxt = in_bar.bar_vwap;
        run_high_nxt   = in_bar.high_price;
        run_low_nxt    = in_bar.low_price;
        wsum_nxt       = '0;
        sat_nxt        = vsum_sat | tsum_sat;
      end else begin
        if (in_bar.high_price > run_high_r) run_high_nxt = in_bar.high_price;
        if (in_bar.low_price < run_low_r)   run_low_nxt  = in_bar.low_price;
        sat_nxt = sat_nxt | vsum_sat | tsum_sat;
      end
    end

    vwap_clamped = (|quotient[WSUM_BITS-1:PRICE_BITS]) ? '1 : quotient[PRICE_BITS-1:0];

    out_nxt = out_r;
    if (cmd.load_out) begin
      out_nxt.merged_time   = first_time_r;
      out_nxt.merged_open   = first_open_r;
      out_nxt.merged_high   = run_high_r;
      out_nxt.merged_low    = run_low_r;
      out_nxt.merged_close  = last_close_r;
      out_nxt.merged_volume = vsum_r;
      out_nxt.merged_trades = tsum_r;
      out_nxt.zero_volume   = (vsum_r == '0);
      out_nxt.merged_vwap   = (vsum_r == '0) ? first_vwap_r : vwap_clamped;
      out_nxt.overflowed    = sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_group_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      in_group_r <= in_group_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    first_time_r <= first_time_nxt;
    first_open_r <= first_open_nxt;
    first_vwap_r <= first_vwap_nxt;
    run_high_r   <= run_high_nxt;
    run_low_r    <= run_low_nxt;
    last_close_r <= last_close_nxt;
    vsum_r       <= vsum_nxt;
    tsum_r       <= tsum_nxt;
    wsum_r       <= wsum_nxt;
    sat_r        <= sat_nxt;
    out_r        <= out_nxt;
  end

  assign sts.div_done = div_done;
  assign out_bar      = out_r;

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !in_group_r) |-> !pend_r)
    else $error("old product pending at group start");

  a_div_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !pend_r)
    else $error("division started before last product folded in");

  a_load_closed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !in_group_r)
    else $error("merged bar loaded while group open");

endmodule

FILE: rtl/obm_ctrl.sv
// ----------------------------------------------------------------------------
// obm_ctrl
// sequencer: accumulate, flush product, divide, hand over merged bar
// ----------------------------------------------------------------------------
module obm_ctrl
  import obm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_tlast,
  output logic    in_tready,
  input  logic    out_tready,
  output logic    out_tvalid,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;

    case (state_r)
      ST_ACCUM: begin
        in_tready       = 1'b1;
        cmd.accept      = in_tvalid;
        cmd.close_group = in_tvalid && in_tlast;
        if (in_tvalid && in_tlast) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.div_done) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = ST_ACCUM;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase

    if (cmd.load_out)     out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("merged bar overwrites one not yet taken");

  a_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (state_r == ST_FLUSH))
    else $error("group end not followed by flush");

  a_done_seen: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_DIVIDE))
    else $error("division finished outside divide state");

endmodule

FILE: rtl/ohlcv_bar_merger.sv
// ----------------------------------------------------------------------------
// ohlcv_bar_merger
// merges each group of ohlcv bars into one bar with a volume weighted vwap
// ----------------------------------------------------------------------------
// Bars of a group are taken one per cycle; the bar that carries tlast closes
// the group. The merged bar keeps the first bar's time and open, the highest
// high, the lowest low and the last close, and sums volume, trade count and
// vwap times volume, each sum saturating and raising the overflow flag.
// After the closing bar tready stays low while the block folds in the last
// product, launches the divider, runs the 64 steps of the bit-serial divider
// that forms weighted sum over volume sum, and loads the result. Beyond that
// it stays low only while an earlier merged bar still waits at the
// output. The output register lets the next group's bars flow in while a
// merged bar waits to be taken. A group with zero total volume passes the
// first bar's vwap through and sets zero_volume; a quotient above the price
// range is clamped to its maximum.
// ----------------------------------------------------------------------------
module ohlcv_bar_merger
  import obm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  // bar input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // bar_time, open_price, high_price, low_price, close_price, bar_volume,
  // bar_trades, bar_vwap, zero fill
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  input  logic                     in_tlast,   // group_end

  // merged bar output stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // merged_time, merged_open, merged_high, merged_low, merged_close,
  // merged_volume, merged_trades, merged_vwap, zero fill
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // zero_volume, overflowed
  output logic [OUT_USER_BITS-1:0] out_tuser
);

  bar_t    in_bar;
  merged_t out_bar;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // unpack the incoming transaction
  assign in_bar.bar_time    = in_tdata[TIME_BITS-1:0];
  assign in_bar.open_price  = in_tdata[IN_OPEN_LSB +: PRICE_BITS];
  assign in_bar.high_price  = in_tdata[IN_HIGH_LSB +: PRICE_BITS];
  assign in_bar.low_price   = in_tdata[IN_LOW_LSB +: PRICE_BITS];
  assign in_bar.close_price = in_tdata[IN_CLOSE_LSB +: PRICE_BITS];
  assign in_bar.bar_volume  = in_tdata[IN_VOL_LSB +: VOLUME_BITS];
  assign in_bar.bar_trades  = in_tdata[IN_TRADES_LSB +: TRADES_BITS];
  assign in_bar.bar_vwap    = in_tdata[IN_VWAP_LSB +: PRICE_BITS];

  // sequencer: owns the handshakes and the output valid
  obm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  // accumulators, divider and output register
  obm_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bar  (in_bar),
    .cmd     (cmd),
    .sts     (sts),
    .out_bar (out_bar)
  );

  // pack the merged bar, lowest field first, zero filled to whole bytes
  assign out_tdata = OUT_DATA_BITS'({out_bar.merged_vwap,
                                     out_bar.merged_trades,
                                     out_bar.merged_volume,
                                     out_bar.merged_close,
                                     out_bar.merged_low,
                                     out_bar.merged_high,
                                     out_bar.merged_open,
                                     out_bar.merged_time});
  assign out_tuser = {out_bar.overflowed, out_bar.zero_volume};

endmodule
